/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmdt_pkg.sv */
`default_nettype none

package pmdt_pkg;

    localparam int ELEM_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int SUM_W      = 63;
    localparam int SQ_W       = 32;
    localparam int DIV_W      = SQ_W + ELEM_W;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_LOAD_VECTOR = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 1'd1;

    localparam logic [COUNT_W-1:0] VECTOR_COUNT_RESET    = 7'd64;
    localparam logic [COUNT_W-1:0] COMPONENT_COUNT_RESET = 7'd63;

    typedef struct packed {
        logic [1:0]               op;
        logic [5:0]               vector_index;
        logic [5:0]               component_index;
        logic signed [ELEM_W-1:0] element_value;
        logic [ELEM_W-1:0]        weight_value;
    } req_t;

    typedef struct packed {
        logic [SUM_W-1:0] euclid_threshold;
        logic [SUM_W-1:0] weighted_threshold;
        logic             zero_weight_seen;
    } result_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_result_t;

    // Saturating add: anything at or above 2^63 clamps to the field maximum.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [SUM_W-1:0] term);
        logic [SUM_W:0] sum;
        sum = {1'b0, acc} + {1'b0, term};
        return sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/pmdt_ram.sv */
`default_nettype none

module pmdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/pmdt_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pmdt_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pmdt_pkg::DIV_W-1:0]  dividend,
    input  wire logic [pmdt_pkg::ELEM_W-1:0] divisor,
    output pmdt_pkg::div_result_t            result
);
    import pmdt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ELEM_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [ELEM_W-1:0]    dsr_reg, dsr_next;

    logic [ELEM_W:0]      trial;
    logic [ELEM_W+1:0]    diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, trial} - {2'b00, dsr_reg};

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[ELEM_W+1])
            begin
                rem_next = diff[ELEM_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ELEM_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/pairwise_max_distance_thresholds.sv */
// Pairwise maximum distance thresholds.
// Requests arrive on req_valid/req_stall/req_data. A weight load or a vector
// component load gives no result; loads may follow each other in every cycle
// while no compute is running. A compute request walks every pair (i, j) with
// i <= j below vector_count and returns one result on result_valid/
// result_stall/result_data: half the largest squared Euclidean distance, half
// the largest weighted distance and a flag for a zero weight in use.
// The compute time is set by the shared divider, which yields one quotient
// bit per cycle, and by the single read port of the vector memory; a
// component with a zero weight skips the divider. req_stall stays high for
// the whole compute.
// The result waits in an output register while result_stall is high; loads
// are still taken meanwhile, and a second compute holds in its final state
// until the register is free. The cfg port (cfg_ready always high) writes the
// two counts and is to be used only while the block is idle.
// Reset empties the output register, sets the counts to 64 and 63 and leaves
// the memories as they were: they must be loaded before use.
`default_nettype none
`include "assert_macros.svh"

module pairwise_max_distance_thresholds #(
    parameter int MAX_VECTORS    = 64,
    parameter int MAX_COMPONENTS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire pmdt_pkg::req_t                 req_data,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output pmdt_pkg::result_t                   result_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pmdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pmdt_pkg::COUNT_W-1:0]   cfg_data
);
    import pmdt_pkg::*;

    localparam int VI_W   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CI_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int DEPTH  = MAX_VECTORS * MAX_COMPONENTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FLAG_RD  = 4'd1;
    localparam logic [3:0] S_FLAG_CHK = 4'd2;
    localparam logic [3:0] S_RDA      = 4'd3;
    localparam logic [3:0] S_RDB      = 4'd4;
    localparam logic [3:0] S_DIFF     = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_ACC      = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_PAIR_END = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] vcount_reg, vcount_next;
    logic [COUNT_W-1:0] ccount_reg, ccount_next;
    logic [VI_W-1:0]    a_reg, a_next;
    logic [VI_W-1:0]    b_reg, b_next;
    logic [CI_W-1:0]    c_reg, c_next;
    logic               result_valid_reg, result_valid_next;

    logic               zero_seen_reg, zero_seen_next;
    logic [ELEM_W-1:0]  xa_reg, xa_next;
    logic [ELEM_W-1:0]  wt_reg, wt_next;
    logic [ELEM_W-1:0]  ad_reg, ad_next;
    logic [SQ_W-1:0]    dd_reg, dd_next;
    logic [SUM_W-1:0]   e_reg, e_next;
    logic [SUM_W-1:0]   w_reg, w_next;
    logic [SUM_W-1:0]   max_e_reg, max_e_next;
    logic [SUM_W-1:0]   max_w_reg, max_w_next;
    result_t            result_data_reg, result_data_next;

    logic [COUNT_W-1:0] nv, nc;
    logic               a_last, b_last, c_last;
    logic               req_accept;
    logic [ELEM_W:0]    diff;

    logic               vec_we, wgt_we;
    logic [ADDR_W-1:0]  vec_waddr, vec_raddr;
    logic [CI_W-1:0]    wgt_waddr, wgt_raddr;
    logic [ELEM_W-1:0]  vec_rdata, wgt_rdata;
    logic               div_start;
    div_result_t        div_res;

    // Counts above the store size are clamped to it.
    assign nv = (32'(vcount_reg) > MAX_VECTORS) ? COUNT_W'(MAX_VECTORS) : vcount_reg;
    assign nc = (32'(ccount_reg) > MAX_COMPONENTS) ? COUNT_W'(MAX_COMPONENTS) : ccount_reg;

    assign a_last = (32'(a_reg) + 32'd1) == 32'(nv);
    assign b_last = (32'(b_reg) + 32'd1) == 32'(nv);
    assign c_last = (32'(c_reg) + 32'd1) == 32'(nc);

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;

    // Loads write straight into the stores; indexes beyond them are dropped.
    assign wgt_we = req_accept && (req_data.op == OP_LOAD_WEIGHT)
                    && (32'(req_data.component_index) < MAX_COMPONENTS);
    assign vec_we = req_accept && (req_data.op == OP_LOAD_VECTOR)
                    && (32'(req_data.component_index) < MAX_COMPONENTS)
                    && (32'(req_data.vector_index) < MAX_VECTORS);
    assign wgt_waddr = CI_W'(req_data.component_index);
    assign vec_waddr = ADDR_W'(32'(req_data.vector_index) * MAX_COMPONENTS
                               + 32'(req_data.component_index));

    always_comb
    begin
        state_next        = state_reg;
        vcount_next       = vcount_reg;
        ccount_next       = ccount_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        c_next            = c_reg;
        result_valid_next = result_valid_reg;
        zero_seen_next    = zero_seen_reg;
        xa_next           = xa_reg;
        wt_next           = wt_reg;
        ad_next           = ad_reg;
        dd_next           = dd_reg;
        e_next            = e_reg;
        w_next            = w_reg;
        max_e_next        = max_e_reg;
        max_w_next        = max_w_reg;
        result_data_next  = result_data_reg;
        vec_raddr         = ADDR_W'(32'(a_reg) * MAX_COMPONENTS + 32'(c_reg));
        wgt_raddr         = c_reg;
        div_start         = 1'b0;
        diff              = {xa_reg[ELEM_W-1], xa_reg} - {vec_rdata[ELEM_W-1], vec_rdata};

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VECTOR_COUNT:    vcount_next = cfg_data;
                CFG_COMPONENT_COUNT: ccount_next = cfg_data;
                default:             ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept && (req_data.op == OP_COMPUTE))
                begin
                    zero_seen_next = 1'b0;
                    max_e_next     = '0;
                    max_w_next     = '0;
                    e_next         = '0;
                    w_next         = '0;
                    a_next         = '0;
                    b_next         = '0;
                    c_next         = '0;
                    // With no components every distance and the flag are zero.
                    state_next     = (nc == '0) ? S_DONE : S_FLAG_RD;
                end
            end

            S_FLAG_RD:
            begin
                state_next = S_FLAG_CHK;
            end

            S_FLAG_CHK:
            begin
                if (wgt_rdata == '0)
                begin
                    zero_seen_next = 1'b1;
                end
                if (c_last)
                begin
                    c_next     = '0;
                    state_next = (nv == '0) ? S_DONE : S_RDA;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_FLAG_RD;
                end
            end

            S_RDA:
            begin
                state_next = S_RDB;
            end

            S_RDB:
            begin
                xa_next    = vec_rdata;
                wt_next    = wgt_rdata;
                vec_raddr  = ADDR_W'(32'(b_reg) * MAX_COMPONENTS + 32'(c_reg));
                state_next = S_DIFF;
            end

            S_DIFF:
            begin
                ad_next    = diff[ELEM_W] ? ELEM_W'(~diff + 1'b1) : diff[ELEM_W-1:0];
                state_next = S_MUL;
            end

            S_MUL:
            begin
                dd_next    = ad_reg * ad_reg;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                e_next = sat_add(e_reg, SUM_W'(dd_reg));
                if (wt_reg == '0)
                begin
                    // A zero weight saturates the term whatever the difference.
                    w_next = SUM_MAX;
                    if (c_last)
                    begin
                        state_next = S_PAIR_END;
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_res.done)
                begin
                    w_next = sat_add(w_reg, SUM_W'(div_res.quotient));
                    if (c_last)
                    begin
                        state_next = S_PAIR_END;
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_RDA;
                    end
                end
            end

            S_PAIR_END:
            begin
                if (e_reg > max_e_reg)
                begin
                    max_e_next = e_reg;
                end
                if (w_reg > max_w_reg)
                begin
                    max_w_next = w_reg;
                end
                e_next = '0;
                w_next = '0;
                c_next = '0;
                if (b_last)
                begin
                    if (a_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        b_next     = a_reg + 1'b1;
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = S_RDA;
                end
            end

            S_DONE:
            begin
                // Hold here until the output register is free.
                if (!result_valid_reg || !result_stall)
                begin
                    result_data_next.euclid_threshold   = max_e_reg >> 1;
                    result_data_next.weighted_threshold = max_w_reg >> 1;
                    result_data_next.zero_weight_seen   = zero_seen_reg;
                    result_valid_next                   = 1'b1;
                    state_next                          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vcount_reg       <= VECTOR_COUNT_RESET;
            ccount_reg       <= COMPONENT_COUNT_RESET;
            a_reg            <= '0;
            b_reg            <= '0;
            c_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vcount_reg       <= vcount_next;
            ccount_reg       <= ccount_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            c_reg            <= c_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_seen_reg   <= zero_seen_next;
        xa_reg          <= xa_next;
        wt_reg          <= wt_next;
        ad_reg          <= ad_next;
        dd_reg          <= dd_next;
        e_reg           <= e_next;
        w_reg           <= w_next;
        max_e_reg       <= max_e_next;
        max_w_reg       <= max_w_next;
        result_data_reg <= result_data_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // The vector store is read twice per component: once for each vector of the pair.
    pmdt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_vector_store (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (req_data.element_value),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    pmdt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_COMPONENTS)
    ) u_weight_store (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (req_data.weight_value),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    // The weighted term is (d*d << 16) / weight, one quotient bit a cycle.
    pmdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dd_reg, {ELEM_W{1'b0}}}),
        .divisor  (wt_reg),
        .result   (div_res)
    );

    // The divider only finishes while the sequencer is waiting for it.
    `ASSERT_IMPLIES(a_div_done_in_wait, clk, rst_n, div_res.done, state_reg == S_DIV,
        "divider finished outside its wait state")

    // Pairs are visited with the second index never below the first.
    `ASSERT_IMPLIES(a_pair_order, clk, rst_n, state_reg == S_RDA, b_reg >= a_reg,
        "pair index order broken")

    // Both thresholds are halved sums, so their top bit is always clear.
    `ASSERT_IMPLIES(a_threshold_range, clk, rst_n, result_valid_reg,
        !result_data_reg.euclid_threshold[SUM_W-1]
            && !result_data_reg.weighted_threshold[SUM_W-1],
        "threshold above half of the saturated sum")

    // A finished compute never overwrites a result that is still stalled.
    `ASSERT_NEXT(a_no_overwrite, clk, rst_n,
        (state_reg == S_DONE) && result_valid_reg && result_stall,
        (state_reg == S_DONE) && result_valid_reg,
        "pending result overwritten")

endmodule

`default_nettype wire
